// ----- hdl/vpnt_pkg.sv -----
`default_nettype none

package vpnt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int CFG_W         = 64;
    localparam int CFG_ADDR_W    = 3;
    localparam int NUM_MAT_REGS  = 6;

    // the largest normalized magnitude sits in [2^(NORM_W-1), 2^NORM_W)
    localparam int NORM_W = 30;
    localparam int ROOT_W = NORM_W + 1;
    localparam int SS_W   = 2 * NORM_W + 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_ROW0_C01 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW0_C23 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW1_C01 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW1_C23 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW2_C01 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW2_C23 = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEEP     = 3'd6;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
        logic signed [DATA_W-1:0] norm_x;
        logic signed [DATA_W-1:0] norm_y;
        logic signed [DATA_W-1:0] norm_z;
        logic                     last_in;
    } t_vtx_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_pos_x;
        logic signed [DATA_W-1:0] out_pos_y;
        logic signed [DATA_W-1:0] out_pos_z;
        logic signed [DATA_W-1:0] out_norm_x;
        logic signed [DATA_W-1:0] out_norm_y;
        logic signed [DATA_W-1:0] out_norm_z;
        logic                     zero_normal;
        logic                     saturated;
        logic                     last_out;
    } t_vtx_out;

    // per-vertex data riding alongside the normalize path
    typedef struct packed {
        logic [2:0][DATA_W-1:0] pos;
        logic [2:0][DATA_W-1:0] keep_norm;
        logic [2:0]             neg;
        logic                   zero;
        logic                   sat;
        logic                   last;
    } t_side;

    typedef struct packed {
        logic [2:0][NORM_W-1:0] mag;
        t_side                  side;
    } t_carry;

endpackage

`default_nettype wire

// ----- hdl/vpnt_sqrt.sv -----
`default_nettype none

module vpnt_sqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [vpnt_pkg::SS_W-1:0]   i_ss,
    input  wire vpnt_pkg::t_carry            i_carry,
    output logic                             o_valid,
    output logic [vpnt_pkg::ROOT_W-1:0]      o_root,
    output vpnt_pkg::t_carry                 o_carry
);
    import vpnt_pkg::*;

    localparam logic [SS_W:0]     TERM_ONE = 1;
    localparam logic [ROOT_W-1:0] ROOT_ONE = 1;

    logic              r_vld  [ROOT_W];
    logic [SS_W-1:0]   r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    t_carry            r_car  [ROOT_W];

    logic              s_vld  [ROOT_W];
    logic [SS_W-1:0]   s_rem  [ROOT_W];
    logic [ROOT_W-1:0] s_root [ROOT_W];
    t_carry            s_car  [ROOT_W];
    logic [SS_W-1:0]   n_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];

    // one root bit per stage, MSB first
    always_comb begin : c_stage
        logic [SS_W:0] term;
        s_vld[0]  = i_valid;
        s_rem[0]  = i_ss;
        s_root[0] = '0;
        s_car[0]  = i_carry;
        for (int k = 1; k < ROOT_W; k++) begin
            s_vld[k]  = r_vld[k-1];
            s_rem[k]  = r_rem[k-1];
            s_root[k] = r_root[k-1];
            s_car[k]  = r_car[k-1];
        end
        for (int k = 0; k < ROOT_W; k++) begin
            term = ({{(SS_W+1-ROOT_W){1'b0}}, s_root[k]} << (ROOT_W - k))
                 | (TERM_ONE << (2 * (ROOT_W - 1 - k)));
            if ({1'b0, s_rem[k]} >= term) begin
                n_rem[k]  = s_rem[k] - term[SS_W-1:0];
                n_root[k] = s_root[k] | (ROOT_ONE << (ROOT_W - 1 - k));
            end else begin
                n_rem[k]  = s_rem[k];
                n_root[k] = s_root[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ROOT_W; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < ROOT_W; k++) r_vld[k] <= s_vld[k];
        end
        if (i_en) begin
            for (int k = 0; k < ROOT_W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_car[k]  <= s_car[k];
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_carry = r_car[ROOT_W-1];

endmodule

`default_nettype wire

// ----- hdl/vpnt_div.sv -----
`default_nettype none

module vpnt_div #(
    parameter int FRAC_BITS = vpnt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [vpnt_pkg::ROOT_W-1:0]   i_len,
    input  wire vpnt_pkg::t_carry              i_carry,
    output logic                               o_valid,
    output logic [2:0][FRAC_BITS:0]            o_q,
    output vpnt_pkg::t_side                    o_side
);
    import vpnt_pkg::*;

    localparam int Q_W   = FRAC_BITS + 1;
    localparam int NUM_W = NORM_W + FRAC_BITS + 1;
    localparam logic [Q_W-1:0] Q_ONE = 1;

    // numerator with half-divisor rounding
    logic              r_p_vld;
    logic [NUM_W-1:0]  r_p_num [3];
    logic [ROOT_W-1:0] r_p_len;
    t_side             r_p_side;

    logic              r_vld  [Q_W];
    logic [NUM_W-1:0]  r_rem  [Q_W][3];
    logic [Q_W-1:0]    r_q    [Q_W][3];
    logic [ROOT_W-1:0] r_len  [Q_W];
    t_side             r_side [Q_W];

    logic              s_vld  [Q_W];
    logic [NUM_W-1:0]  s_rem  [Q_W][3];
    logic [Q_W-1:0]    s_q    [Q_W][3];
    logic [ROOT_W-1:0] s_len  [Q_W];
    t_side             s_side [Q_W];
    logic [NUM_W-1:0]  n_rem  [Q_W][3];
    logic [Q_W-1:0]    n_q    [Q_W][3];

    always_comb begin : c_stage
        logic [NUM_W-1:0] dvs;
        s_vld[0]  = r_p_vld;
        s_len[0]  = r_p_len;
        s_side[0] = r_p_side;
        for (int a = 0; a < 3; a++) begin
            s_rem[0][a] = r_p_num[a];
            s_q[0][a]   = '0;
        end
        for (int k = 1; k < Q_W; k++) begin
            s_vld[k]  = r_vld[k-1];
            s_len[k]  = r_len[k-1];
            s_side[k] = r_side[k-1];
            for (int a = 0; a < 3; a++) begin
                s_rem[k][a] = r_rem[k-1][a];
                s_q[k][a]   = r_q[k-1][a];
            end
        end
        for (int k = 0; k < Q_W; k++) begin
            dvs = NUM_W'(s_len[k]) << (FRAC_BITS - k);
            for (int a = 0; a < 3; a++) begin
                if (s_rem[k][a] >= dvs) begin
                    n_rem[k][a] = s_rem[k][a] - dvs;
                    n_q[k][a]   = s_q[k][a] | (Q_ONE << (FRAC_BITS - k));
                end else begin
                    n_rem[k][a] = s_rem[k][a];
                    n_q[k][a]   = s_q[k][a];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            for (int k = 0; k < Q_W; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_p_vld <= i_valid;
            for (int k = 0; k < Q_W; k++) r_vld[k] <= s_vld[k];
        end
        if (i_en) begin
            r_p_len  <= i_len;
            r_p_side <= i_carry.side;
            for (int a = 0; a < 3; a++) begin
                r_p_num[a] <= NUM_W'({i_carry.mag[a], {FRAC_BITS{1'b0}}})
                            + NUM_W'(i_len >> 1);
            end
            for (int k = 0; k < Q_W; k++) begin
                r_len[k]  <= s_len[k];
                r_side[k] <= s_side[k];
                for (int a = 0; a < 3; a++) begin
                    r_rem[k][a] <= n_rem[k][a];
                    r_q[k][a]   <= n_q[k][a];
                end
            end
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_side  = r_side[Q_W-1];
    assign o_q[0]  = r_q[Q_W-1][0];
    assign o_q[1]  = r_q[Q_W-1][1];
    assign o_q[2]  = r_q[Q_W-1][2];

endmodule

`default_nettype wire

// ----- hdl/vertex_position_normal_transform.sv -----
`default_nettype none

// channel   direction  handshake           payload
// vertex    in         i_valid / o_stall   i_data  (t_vtx_in)
// result    out        o_valid / i_stall   o_data  (t_vtx_out)
// config    in         i_cfg_we            i_cfg_addr, i_cfg_wdata
//
// One vertex per cycle sustained while i_stall does not hold a result; the normal
// path runs through the 31-stage square root and the FRAC_BITS + 2 stage divider.
// Synchronous active-low reset clears valid bits and loads the identity matrix.
// A stalled result freezes the whole pipeline; o_stall follows i_stall while
// a result is held, and nothing is dropped or repeated.

module vertex_position_normal_transform #(
    parameter int FRAC_BITS = vpnt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire vpnt_pkg::t_vtx_in                i_data,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output vpnt_pkg::t_vtx_out                    o_data,
    input  wire logic                             i_cfg_we,
    input  wire logic [vpnt_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [vpnt_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import vpnt_pkg::*;

    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RW     = SUM_W - FRAC_BITS;
    localparam int TW     = RW + 1;
    localparam int HB_W   = $clog2(RW);
    localparam int SQ_W   = 2 * NORM_W;

    localparam logic [SUM_W-1:0]  RND     = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic [DATA_W-1:0] ONE_FIX = DATA_W'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [HB_W-1:0]   TOP_BIT = HB_W'(NORM_W - 1);
    localparam logic [ROOT_W-1:0] ROOT_LO = ROOT_W'(1) << (NORM_W - 1);
    localparam logic signed [DATA_W-1:0] UNIT_HI = ONE_FIX;
    localparam logic signed [DATA_W-1:0] UNIT_LO = -UNIT_HI;

    logic en;

    // configuration
    logic [CFG_W-1:0] r_mat [NUM_MAT_REGS];
    logic             r_keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[0] <= CFG_W'(ONE_FIX);
            r_mat[1] <= '0;
            r_mat[2] <= CFG_W'(ONE_FIX) << DATA_W;
            r_mat[3] <= '0;
            r_mat[4] <= '0;
            r_mat[5] <= CFG_W'(ONE_FIX);
            r_keep   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ROW0_C01: r_mat[0] <= i_cfg_wdata;
                CFG_ROW0_C23: r_mat[1] <= i_cfg_wdata;
                CFG_ROW1_C01: r_mat[2] <= i_cfg_wdata;
                CFG_ROW1_C23: r_mat[3] <= i_cfg_wdata;
                CFG_ROW2_C01: r_mat[4] <= i_cfg_wdata;
                CFG_ROW2_C23: r_mat[5] <= i_cfg_wdata;
                CFG_KEEP:     r_keep   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic signed [DATA_W-1:0] m_el  [3][4];
    logic signed [DATA_W-1:0] v_pos [3];
    logic signed [DATA_W-1:0] v_nrm [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
                m_el[r][c] = c[0] ? r_mat[2*r + (c >> 1)][CFG_W-1:DATA_W]
                                  : r_mat[2*r + (c >> 1)][DATA_W-1:0];
            end
        end
        v_pos[0] = i_data.pos_x;
        v_pos[1] = i_data.pos_y;
        v_pos[2] = i_data.pos_z;
        v_nrm[0] = i_data.norm_x;
        v_nrm[1] = i_data.norm_y;
        v_nrm[2] = i_data.norm_z;
    end

    // S1: products
    logic                     r1_vld, r1_last;
    logic signed [PROD_W-1:0] r1_pp [3][3];
    logic signed [PROD_W-1:0] r1_pn [3][3];

    // S2: rounded row sums
    logic                 r2_vld, r2_last;
    logic signed [RW-1:0] r2_pr [3];
    logic signed [RW-1:0] r2_nr [3];
    logic signed [RW-1:0] n2_pr [3];
    logic signed [RW-1:0] n2_nr [3];

    always_comb begin : c_s2
        logic signed [SUM_W-1:0] acc_p;
        logic signed [SUM_W-1:0] acc_n;
        for (int r = 0; r < 3; r++) begin
            acc_p = SUM_W'(r1_pp[r][0]) + SUM_W'(r1_pp[r][1]) + SUM_W'(r1_pp[r][2]) + RND;
            acc_n = SUM_W'(r1_pn[r][0]) + SUM_W'(r1_pn[r][1]) + SUM_W'(r1_pn[r][2]) + RND;
            n2_pr[r] = acc_p[SUM_W-1:FRAC_BITS];
            n2_nr[r] = acc_n[SUM_W-1:FRAC_BITS];
        end
    end

    // S3: translate, clip, magnitudes
    logic          r3_vld;
    logic [RW-1:0] r3_mag [3];
    t_side         r3_side;
    logic [RW-1:0] n3_mag [3];
    t_side         n3_side;

    always_comb begin : c_s3
        logic signed [TW-1:0] t;
        logic                 pclip;
        logic                 nclip;
        pclip = 1'b0;
        nclip = 1'b0;
        for (int r = 0; r < 3; r++) begin
            t = TW'(r2_pr[r]) + TW'(m_el[r][3]);
            if (t[TW-1:DATA_W-1] != {(TW-DATA_W+1){t[TW-1]}}) begin
                pclip = 1'b1;
                n3_side.pos[r] = t[TW-1] ? MIN_NEG : MAX_POS;
            end else begin
                n3_side.pos[r] = t[DATA_W-1:0];
            end
            if (r2_nr[r][RW-1:DATA_W-1] != {(RW-DATA_W+1){r2_nr[r][RW-1]}}) begin
                nclip = 1'b1;
                n3_side.keep_norm[r] = r2_nr[r][RW-1] ? MIN_NEG : MAX_POS;
            end else begin
                n3_side.keep_norm[r] = r2_nr[r][DATA_W-1:0];
            end
            n3_side.neg[r] = r2_nr[r][RW-1];
            n3_mag[r] = r2_nr[r][RW-1] ? RW'(-r2_nr[r]) : RW'(r2_nr[r]);
        end
        n3_side.zero = (n3_mag[0] | n3_mag[1] | n3_mag[2]) == '0;
        n3_side.sat  = pclip | (r_keep & nclip);
        n3_side.last = r2_last;
    end

    // S4: leading one of the largest magnitude
    logic            r4_vld;
    logic [HB_W-1:0] r4_h;
    logic [RW-1:0]   r4_mag [3];
    t_side           r4_side;
    logic [HB_W-1:0] n4_h;

    always_comb begin : c_s4
        logic [RW-1:0] orw;
        orw  = r3_mag[0] | r3_mag[1] | r3_mag[2];
        n4_h = '0;
        for (int b = 0; b < RW; b++) begin
            if (orw[b]) n4_h = HB_W'(b);
        end
    end

    // S5: common shift
    logic              r5_vld;
    logic [NORM_W-1:0] r5_mag [3];
    t_side             r5_side;
    logic [NORM_W-1:0] n5_mag [3];

    always_comb begin : c_s5
        logic [RW-1:0] sh;
        for (int a = 0; a < 3; a++) begin
            if (r4_h >= TOP_BIT) sh = r4_mag[a] >> (r4_h - TOP_BIT);
            else                 sh = r4_mag[a] << (TOP_BIT - r4_h);
            n5_mag[a] = sh[NORM_W-1:0];
        end
    end

    // S6: squares, S7: sum of squares
    logic              r6_vld;
    logic [SQ_W-1:0]   r6_sq  [3];
    logic [NORM_W-1:0] r6_mag [3];
    t_side             r6_side;

    logic              r7_vld;
    logic [SS_W-1:0]   r7_ss;
    t_carry            r7_carry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
        end
        if (en) begin
            r1_last <= i_data.last_in;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r1_pp[r][c] <= PROD_W'(m_el[r][c]) * PROD_W'(v_pos[c]);
                    r1_pn[r][c] <= PROD_W'(m_el[r][c]) * PROD_W'(v_nrm[c]);
                end
            end
            r2_last <= r1_last;
            r3_side <= n3_side;
            r4_h    <= n4_h;
            r4_side <= r3_side;
            r5_side <= r4_side;
            r6_side <= r5_side;
            for (int a = 0; a < 3; a++) begin
                r2_pr[a]  <= n2_pr[a];
                r2_nr[a]  <= n2_nr[a];
                r3_mag[a] <= n3_mag[a];
                r4_mag[a] <= r3_mag[a];
                r5_mag[a] <= n5_mag[a];
                r6_sq[a]  <= SQ_W'(r5_mag[a]) * SQ_W'(r5_mag[a]);
                r6_mag[a] <= r5_mag[a];
                r7_carry.mag[a] <= r6_mag[a];
            end
            r7_ss         <= SS_W'(r6_sq[0]) + SS_W'(r6_sq[1]) + SS_W'(r6_sq[2]);
            r7_carry.side <= r6_side;
        end
    end

    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    t_carry            sq_carry;

    vpnt_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_vld),
        .i_ss    (r7_ss),
        .i_carry (r7_carry),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_carry (sq_carry)
    );

    logic                   dv_vld;
    logic [2:0][FRAC_BITS:0] dv_q;
    t_side                  dv_side;

    vpnt_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_vld),
        .i_len   (sq_root),
        .i_carry (sq_carry),
        .o_valid (dv_vld),
        .o_q     (dv_q),
        .o_side  (dv_side)
    );

    // output register
    logic     r_out_vld;
    t_vtx_out r_out;
    t_vtx_out n_out;

    always_comb begin : c_out
        logic [DATA_W-1:0] qv;
        logic [DATA_W-1:0] nv [3];
        for (int a = 0; a < 3; a++) begin
            qv = DATA_W'(dv_q[a]);
            if (r_keep)            nv[a] = dv_side.keep_norm[a];
            else if (dv_side.zero) nv[a] = '0;
            else                   nv[a] = dv_side.neg[a] ? DATA_W'(0) - qv : qv;
        end
        n_out.out_pos_x   = dv_side.pos[0];
        n_out.out_pos_y   = dv_side.pos[1];
        n_out.out_pos_z   = dv_side.pos[2];
        n_out.out_norm_x  = nv[0];
        n_out.out_norm_y  = nv[1];
        n_out.out_norm_z  = nv[2];
        n_out.zero_normal = ~r_keep & dv_side.zero;
        n_out.saturated   = dv_side.sat;
        n_out.last_out    = dv_side.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= dv_vld;
        end
        if (en) begin
            r_out <= n_out;
        end
    end

    assign en      = ~(r_out_vld & i_stall);
    assign o_stall = r_out_vld & i_stall;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    a_keep_no_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(r_keep && o_data.zero_normal))
        else $error("zero_normal set in keep mode");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_vld && !sq_carry.side.zero |-> sq_root >= ROOT_LO)
        else $error("normal length below normalized range");

    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !r_keep |->
            (o_data.out_norm_x <= UNIT_HI) && (o_data.out_norm_x >= UNIT_LO) &&
            (o_data.out_norm_y <= UNIT_HI) && (o_data.out_norm_y >= UNIT_LO) &&
            (o_data.out_norm_z <= UNIT_HI) && (o_data.out_norm_z >= UNIT_LO))
        else $error("normalized component above unit");

endmodule

`default_nettype wire

// ----- tb/vertex_position_normal_transform_test.sv -----
`timescale 1ns / 1ps

module vertex_position_normal_transform_test;
    import vpnt_pkg::*;

    localparam int FB = 16;
    localparam int LATENCY = FB + 41;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_vtx_in i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_vtx_out o_data;
    logic i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    logic [CFG_W-1:0] mat_regs [NUM_MAT_REGS];
    logic keep_len;
    t_vtx_out expected_q[$];
    int n_errors = 0;
    int idle_cycles = 0;
    bit stall_quiet = 1'b0;
    bit send_quiet = 1'b0;

    always #5 i_clk = ~i_clk;

    vertex_position_normal_transform dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [63:0] mat_elem(int row, int col);
        logic [63:0] r;
        r = mat_regs[row * 2 + col / 2];
        return (col % 2) ? 64'(signed'(r[63:32])) : 64'(signed'(r[31:0]));
    endfunction

    function automatic logic signed [63:0] row_sum(int row, logic signed [63:0] v [3]);
        logic signed [127:0] acc;
        acc = 0;
        for (int c = 0; c < 3; c++) acc += 128'(mat_elem(row, c)) * 128'(v[c]);
        acc = acc + (128'sd1 <<< (FB - 1));
        return 64'(acc >>> FB);
    endfunction

    function automatic logic signed [63:0] clip32(logic signed [63:0] v, ref bit clip);
        if (v > 64'sh7FFFFFFF) begin
            clip = 1'b1;
            return 64'sh7FFFFFFF;
        end
        if (v < -64'sh80000000) begin
            clip = 1'b1;
            return -64'sh80000000;
        end
        return v;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_vtx_out transform_vertex(t_vtx_in v);
        t_vtx_out o;
        logic signed [63:0] p [3];
        logic signed [63:0] n [3];
        logic signed [63:0] op [3];
        logic signed [63:0] on [3];
        logic [63:0] mag [3];
        logic [63:0] mx, ss, len, q;
        bit clip, zero;
        clip = 0;
        zero = 0;
        p[0] = v.pos_x; p[1] = v.pos_y; p[2] = v.pos_z;
        n[0] = v.norm_x; n[1] = v.norm_y; n[2] = v.norm_z;
        for (int i = 0; i < 3; i++) begin
            op[i] = clip32(row_sum(i, p) + mat_elem(i, 3), clip);
            on[i] = row_sum(i, n);
        end
        if (keep_len) begin
            for (int i = 0; i < 3; i++) on[i] = clip32(on[i], clip);
        end else begin
            mx = 0;
            for (int i = 0; i < 3; i++) begin
                mag[i] = on[i] < 0 ? 64'(-on[i]) : 64'(on[i]);
                if (mag[i] > mx) mx = mag[i];
            end
            if (mx == 0) begin
                zero = 1;
                for (int i = 0; i < 3; i++) on[i] = 0;
            end else begin
                while (mx >= (64'd1 << 30)) begin
                    mx >>= 1;
                    for (int i = 0; i < 3; i++) mag[i] >>= 1;
                end
                while (mx < (64'd1 << 29)) begin
                    mx <<= 1;
                    for (int i = 0; i < 3; i++) mag[i] <<= 1;
                end
                ss = 0;
                for (int i = 0; i < 3; i++) ss += mag[i] * mag[i];
                len = int_sqrt(ss);
                for (int i = 0; i < 3; i++) begin
                    q = ((mag[i] << FB) + (len >> 1)) / len;
                    on[i] = on[i] < 0 ? -64'(q) : 64'(q);
                end
            end
        end
        o.out_pos_x = op[0][31:0]; o.out_pos_y = op[1][31:0]; o.out_pos_z = op[2][31:0];
        o.out_norm_x = on[0][31:0]; o.out_norm_y = on[1][31:0]; o.out_norm_z = on[2][31:0];
        o.zero_normal = zero;
        o.saturated = clip;
        o.last_out = v.last_in;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    task automatic send_vertex(t_vtx_in v);
        int g;
        g = send_quiet ? 0 : gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_q.push_back(transform_vertex(v));
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        if (idx < NUM_MAT_REGS) mat_regs[idx] = val;
        else if (idx == CFG_KEEP) keep_len = val[0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(signed'($urandom_range(0, 8 << FB)) - (4 << FB));
            3: return 32'h0;
            default: return 32'(signed'($urandom_range(0, 4 << FB)) - (2 << FB));
        endcase
    endfunction

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'h0;
            4: return 32'(signed'($urandom_range(0, 3)) - 1);
            default: return 32'(signed'($urandom_range(0, 200 << FB)) - (100 << FB));
        endcase
    endfunction

    function automatic t_vtx_in rand_vertex();
        t_vtx_in v;
        v.pos_x = rand_comp(); v.pos_y = rand_comp(); v.pos_z = rand_comp();
        v.norm_x = rand_comp(); v.norm_y = rand_comp(); v.norm_z = rand_comp();
        if ($urandom_range(0, 9) == 0) begin
            v.norm_x = 0; v.norm_y = 0; v.norm_z = 0;
        end
        v.last_in = 1'($urandom_range(0, 1));
        return v;
    endfunction

    function automatic t_vtx_in mk(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                   logic [31:0] d, logic [31:0] e, logic [31:0] f, bit l);
        t_vtx_in v;
        v.pos_x = a; v.pos_y = b; v.pos_z = c;
        v.norm_x = d; v.norm_y = e; v.norm_z = f;
        v.last_in = l;
        return v;
    endfunction

    task automatic test_directed_identity();
        send_vertex(mk(0, 0, 0, 0, 0, 0, 0));
        send_vertex(mk(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
                       32'h7FFFFFFF, 32'h80000000, 32'h00000001, 1));
        send_vertex(mk(32'h00010000, 32'h00008000, 32'hFFFF8000, 1, 0, 0, 0));
        send_vertex(mk(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F,
                       32'h00010000, 32'h00010000, 32'h00010000, 1));
        send_vertex(mk(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                       32'h80000000, 32'h80000000, 32'h80000000, 0));
        send_vertex(mk(32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                       32'hAAAAAAAA, 32'h55555555, 32'h00030000, 1));
        drain();
    endtask

    task automatic test_directed_extremes();
        for (int r = 0; r < NUM_MAT_REGS; r++)
            write_reg(CFG_ADDR_W'(r), 64'h7FFFFFFF_7FFFFFFF);
        write_reg(CFG_KEEP, CFG_W'(1));
        send_vertex(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                       32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1));
        send_vertex(mk(32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000000, 32'h80000000, 32'h80000000, 0));
        send_vertex(mk(0, 0, 0, 0, 0, 0, 1));
        drain();
        for (int r = 0; r < NUM_MAT_REGS; r++)
            write_reg(CFG_ADDR_W'(r), 64'h80000000_80000000);
        send_vertex(mk(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                       32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0));
        send_vertex(mk(1, 1, 1, 32'hFFFFFFFF, 0, 1, 1));
        drain();
        write_reg(CFG_UNUSED, 64'hFFFFFFFF_FFFFFFFF);
        write_reg(CFG_KEEP, 64'hFFFFFFFF_FFFFFFFE);
        send_vertex(mk(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                       32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0));
        send_vertex(mk(0, 0, 0, 0, 0, 0, 1));
        send_vertex(mk(0, 0, 0, 1, 1, 0, 0));
        drain();
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 9; ph++) begin
            for (int r = 0; r < NUM_MAT_REGS; r++)
                write_reg(CFG_ADDR_W'(r), {rand_elem(), rand_elem()});
            write_reg(CFG_KEEP, CFG_W'($urandom_range(0, 1)));
            send_quiet = (ph == 3);
            stall_quiet = (ph == 5);
            for (int k = 0; k < 50; k++) send_vertex(rand_vertex());
            send_quiet = 0;
            stall_quiet = 0;
            drain();
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n || stall_quiet) i_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 5) i_stall <= 1'b1;
        else if (i_stall && $urandom_range(0, 99) < 30) i_stall <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_vtx_out w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                $display("unexpected result transfer at %0t", $realtime);
                n_errors++;
            end else begin
                w = expected_q.pop_front();
                if (o_data.out_pos_x !== w.out_pos_x)
                    report_mismatch("out_pos_x", o_data.out_pos_x, w.out_pos_x);
                if (o_data.out_pos_y !== w.out_pos_y)
                    report_mismatch("out_pos_y", o_data.out_pos_y, w.out_pos_y);
                if (o_data.out_pos_z !== w.out_pos_z)
                    report_mismatch("out_pos_z", o_data.out_pos_z, w.out_pos_z);
                if (o_data.out_norm_x !== w.out_norm_x)
                    report_mismatch("out_norm_x", o_data.out_norm_x, w.out_norm_x);
                if (o_data.out_norm_y !== w.out_norm_y)
                    report_mismatch("out_norm_y", o_data.out_norm_y, w.out_norm_y);
                if (o_data.out_norm_z !== w.out_norm_z)
                    report_mismatch("out_norm_z", o_data.out_norm_z, w.out_norm_z);
                if (o_data.zero_normal !== w.zero_normal)
                    report_mismatch("zero_normal", o_data.zero_normal, w.zero_normal);
                if (o_data.saturated !== w.saturated)
                    report_mismatch("saturated", o_data.saturated, w.saturated);
                if (o_data.last_out !== w.last_out)
                    report_mismatch("last_out", o_data.last_out, w.last_out);
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("vertex_position_normal_transform_test: errors");
            $finish;
        end
    end

    initial begin
        mat_regs[0] = 64'd65536;
        mat_regs[1] = 0;
        mat_regs[2] = 64'd281474976710656;
        mat_regs[3] = 0;
        mat_regs[4] = 0;
        mat_regs[5] = 64'd65536;
        keep_len = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_identity();
        test_directed_extremes();
        test_random_settings();
        if (n_errors == 0 && expected_q.size() == 0)
            $display("vertex_position_normal_transform_test: clean");
        else
            $display("vertex_position_normal_transform_test: errors");
        $finish;
    end

endmodule
